FILE: src/irc39_pkg.sv
// Package for the Code 39 reader: payload and status structs, sizing constants,
// the Code 39 symbol tables and the frame match function.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps

package irc39_pkg;

    localparam int RUN_SLOTS   = 29;
    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int CFG_BITS    = 32;
    localparam int CHAR_BITS   = 7;
    localparam int FRAME_COUNT = 38;
    localparam int SYMBOL_LEN  = 9;

    localparam int ADDR_BITS      = $clog2(RUN_SLOTS);
    localparam int COUNT_BITS     = $clog2(RUN_SLOTS + 1);
    localparam int FRAME_IDX_BITS = $clog2(FRAME_COUNT);
    localparam int CMP_BITS       = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RUN_US       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE_TIMEOUT_US = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] BLACK_THRESHOLD_RESET = SAMPLE_BITS'(2300);
    localparam logic [CFG_BITS-1:0]    MIN_RUN_RESET         = CFG_BITS'(10000);
    localparam logic [CFG_BITS-1:0]    WHITE_TIMEOUT_RESET   = CFG_BITS'(3000000);

    localparam logic [CHAR_BITS-1:0] CHAR_UNKNOWN = 7'd63;   // '?'
    localparam logic [FRAME_IDX_BITS-1:0] STAR_IDX = FRAME_IDX_BITS'(FRAME_COUNT - 1);

    // Wide-element masks: bit i set means element i of the symbol is wide.
    localparam logic [SYMBOL_LEN-1:0] SYM_MASK [FRAME_COUNT] = '{
        9'd88,  9'd265, 9'd268, 9'd13,  9'd280, 9'd25,  9'd28,  9'd328, 9'd73,  9'd76,
        9'd289, 9'd292, 9'd37,  9'd304, 9'd49,  9'd52,  9'd352, 9'd97,  9'd100, 9'd112,
        9'd385, 9'd388, 9'd133, 9'd400, 9'd145, 9'd148, 9'd448, 9'd193, 9'd196, 9'd208,
        9'd259, 9'd262, 9'd7,   9'd274, 9'd19,  9'd22,  9'd322, 9'd82
    };

    // ASCII of "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-*"
    localparam logic [CHAR_BITS-1:0] SYM_CHAR [FRAME_COUNT] = '{
        7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
        7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73, 7'd74,
        7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84,
        7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90, 7'd45, 7'd42
    };

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_first;
        logic [SAMPLE_BITS-1:0] sample_second;
        logic [TIME_BITS-1:0]   time_us;
    } sample_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 is_last;
    } result_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] black_threshold;
        logic [CFG_BITS-1:0]    min_run;
        logic [CFG_BITS-1:0]    white_timeout;
    } cfg_t;

    typedef struct packed {
        logic                 full;
        logic                 timeout;
        logic [TIME_BITS-1:0] widest;
    } track_event_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [TIME_BITS-1:0] data;
    } run_write_t;

    typedef struct packed {
        logic                 done;
        logic [RUN_SLOTS-1:0] fwd;
        logic [RUN_SLOTS-1:0] rev;
    } walk_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } state_t;

    // Frame: start star, narrow gap, character, narrow gap, stop star.
    function automatic logic [RUN_SLOTS-1:0] frame_mask(input logic [FRAME_IDX_BITS-1:0] k);
        return {SYM_MASK[STAR_IDX], 1'b0, SYM_MASK[k], 1'b0, SYM_MASK[STAR_IDX]};
    endfunction

    // First frame in table order that matches forward or reversed wins.
    function automatic logic [CHAR_BITS-1:0] match_frame(input logic [RUN_SLOTS-1:0] fwd,
                                                         input logic [RUN_SLOTS-1:0] rev);
        logic [CHAR_BITS-1:0] ch;
        logic                 hit;
        logic [RUN_SLOTS-1:0] f;
        ch  = CHAR_UNKNOWN;
        hit = 1'b0;
        for (int k = 0; k < FRAME_COUNT; k++)
        begin
            f = frame_mask(FRAME_IDX_BITS'(k));
            if (!hit && (fwd == f || rev == f))
            begin
                ch  = SYM_CHAR[FRAME_IDX_BITS'(k)];
                hit = 1'b1;
            end
        end
        return ch;
    endfunction

endpackage

FILE: src/ir_barcode_code39_reader_top.sv
// Top level of the Code 39 reader: configuration registers, decode sequencer
// and result register. Depends on irc39_pkg, irc39_track and irc39_walk.
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  sample    in         sample_valid/stall      sample_t: two readings, time_us
//  result    out        result_valid/stall      result_t: char_code, is_last
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  A sample beat that causes no decode leaves the reader idle, so the next beat
//  can be taken without a stall. A full-buffer decode reads one run slot per
//  cycle through the run memory read port and the shared compare unit before its
//  result shows; a white-timeout '?' shows in the cycle after the beat.
//  sample_stall stays high from a decoding beat until its last result is taken.
//  Reset clears all tracking and control state; run slots are not cleared, as
//  only slots written in the current capture are ever read.
//  A stalled result holds in the output register until taken.

module ir_barcode_code39_reader_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  irc39_pkg::sample_t                sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output irc39_pkg::result_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irc39_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [irc39_pkg::CFG_BITS-1:0]    cfg_data
);
    import irc39_pkg::*;

    state_t       state_reg, state_next;
    cfg_t         cfg_reg;
    result_t      result_reg;
    logic         pend_reg;
    logic         step;
    logic         taken;
    logic         walk_start;
    track_event_t ev;
    run_write_t   wr;
    walk_status_t walk;

    // Configuration: always ready; writes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_threshold <= BLACK_THRESHOLD_RESET;
            cfg_reg.min_run         <= MIN_RUN_RESET;
            cfg_reg.white_timeout   <= WHITE_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLACK_THRESHOLD:  cfg_reg.black_threshold <= cfg_data[SAMPLE_BITS-1:0];
                CFG_MIN_RUN_US:       cfg_reg.min_run         <= cfg_data;
                CFG_WHITE_TIMEOUT_US: cfg_reg.white_timeout   <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign step       = sample_valid && !sample_stall;
    assign taken      = result_valid && !result_stall;
    assign walk_start = step && ev.full;

    irc39_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (sample),
        .cfg    (cfg_reg),
        .ev     (ev),
        .wr     (wr)
    );

    irc39_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .start  (walk_start),
        .widest (ev.widest),
        .status (walk)
    );

    // Next state: walk the runs on a full buffer, emit directly on a lone timeout.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (step && ev.full)
                    state_next = S_WALK;
                else if (step && ev.timeout)
                    state_next = S_EMIT;
            end
            S_WALK:
            begin
                if (walk.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (taken && !pend_reg)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: hold the input off outside idle, show the result register in emit.
    always_comb
    begin
        sample_stall = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:  sample_stall = 1'b0;
            S_WALK:  ;
            S_EMIT:  result_valid = 1'b1;
            default: ;
        endcase
    end

    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (walk_start)
                pend_reg <= ev.timeout;
            else if (state_reg == S_EMIT && taken)
                pend_reg <= 1'b0;
        end
    end

    // Result payload: a lone timeout '?', or the matched character then the timeout '?' if pending.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && step && !ev.full && ev.timeout)
        begin
            result_reg.char_code <= CHAR_UNKNOWN;
            result_reg.is_last   <= 1'b1;
        end
        else if (state_reg == S_WALK && walk.done)
        begin
            result_reg.char_code <= match_frame(walk.fwd, walk.rev);
            result_reg.is_last   <= !pend_reg;
        end
        else if (state_reg == S_EMIT && taken && pend_reg)
        begin
            result_reg.char_code <= CHAR_UNKNOWN;
            result_reg.is_last   <= 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sample_stall)
        else $error("sample accepted while a result is pending");

    a_walk_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk.done |-> (state_reg == S_WALK))
        else $error("run walk finished outside the walk state");

    a_pair_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && !result.is_last) |=> result_valid)
        else $error("non-final result not followed by another result");

    a_pair_second_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && !result.is_last) |=> (result.char_code == CHAR_UNKNOWN && result.is_last))
        else $error("second result of a pair is not a final unknown character");
`endif

endmodule

FILE: src/irc39_track.sv
// Per-beat tracking: threshold, run timing, run store requests and decode triggers.
// Depends on irc39_pkg.
`timescale 1ns / 1ps

module irc39_track (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  irc39_pkg::sample_t      sample,
    input  irc39_pkg::cfg_t         cfg,
    output irc39_pkg::track_event_t ev,
    output irc39_pkg::run_write_t   wr
);
    import irc39_pkg::*;

    logic [COUNT_BITS-1:0] run_count_reg, run_count_next;
    logic [TIME_BITS-1:0]  widest_reg, widest_next;
    logic                  capture_reg, capture_next;
    logic                  first_black_reg, first_black_next;
    logic                  prev_black_reg, prev_black_next;
    logic [TIME_BITS-1:0]  last_edge_reg, last_edge_next;
    logic                  white_timing_reg, white_timing_next;
    logic [TIME_BITS-1:0]  white_start_reg, white_start_next;

    logic [SAMPLE_BITS:0]   avg_sum;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   black;
    logic                   run_edge;
    logic                   store;
    logic                   full;
    logic                   timeout;
    logic [TIME_BITS-1:0]   dur;
    logic [TIME_BITS-1:0]   white_span;

    always_comb
    begin
        run_count_next    = run_count_reg;
        widest_next       = widest_reg;
        capture_next      = capture_reg;
        first_black_next  = first_black_reg;
        prev_black_next   = prev_black_reg;
        last_edge_next    = last_edge_reg;
        white_timing_next = white_timing_reg;
        white_start_next  = white_start_reg;
        timeout           = 1'b0;

        avg_sum = {1'b0, sample.sample_first} + {1'b0, sample.sample_second};
        avg     = avg_sum[SAMPLE_BITS:1];
        black   = avg > cfg.black_threshold;

        // Start a capture on the first black sample.
        if (!capture_reg && black)
        begin
            capture_next     = 1'b1;
            run_count_next   = '0;
            widest_next      = '0;
            first_black_next = 1'b0;
            last_edge_next   = sample.time_us;
        end
        if (capture_next && !first_black_next && black)
        begin
            first_black_next = 1'b1;
            prev_black_next  = 1'b1;
        end

        run_edge = capture_next && first_black_next && (black != prev_black_next);
        dur      = sample.time_us - last_edge_next;
        store    = run_edge && (CMP_BITS'(dur) > CMP_BITS'(cfg.min_run))
                   && (run_count_next < COUNT_BITS'(RUN_SLOTS));

        wr.we   = step && store;
        wr.addr = run_count_next[ADDR_BITS-1:0];
        wr.data = dur;

        if (store)
        begin
            if (dur > widest_next)
                widest_next = dur;
            run_count_next = run_count_next + COUNT_BITS'(1);
        end

        full      = run_edge && (run_count_next == COUNT_BITS'(RUN_SLOTS));
        ev.widest = widest_next;

        if (full)
        begin
            run_count_next   = '0;
            widest_next      = '0;
            first_black_next = 1'b0;
            capture_next     = 1'b0;
        end
        if (run_edge)
        begin
            prev_black_next = black;
            last_edge_next  = sample.time_us;
        end

        white_span = sample.time_us - white_start_reg;
        if (!black)
        begin
            if (!white_timing_reg)
            begin
                white_timing_next = 1'b1;
                white_start_next  = sample.time_us;
            end
            else if (CMP_BITS'(white_span) > CMP_BITS'(cfg.white_timeout))
            begin
                timeout           = 1'b1;
                run_count_next    = '0;
                widest_next       = '0;
                first_black_next  = 1'b0;
                capture_next      = 1'b0;
                white_timing_next = 1'b0;
            end
        end
        else
        begin
            white_timing_next = 1'b0;
        end

        ev.full    = full;
        ev.timeout = timeout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg    <= '0;
            widest_reg       <= '0;
            capture_reg      <= 1'b0;
            first_black_reg  <= 1'b0;
            prev_black_reg   <= 1'b0;
            last_edge_reg    <= '0;
            white_timing_reg <= 1'b0;
            white_start_reg  <= '0;
        end
        else if (step)
        begin
            run_count_reg    <= run_count_next;
            widest_reg       <= widest_next;
            capture_reg      <= capture_next;
            first_black_reg  <= first_black_next;
            prev_black_reg   <= prev_black_next;
            last_edge_reg    <= last_edge_next;
            white_timing_reg <= white_timing_next;
            white_start_reg  <= white_start_next;
        end
    end

endmodule

FILE: src/irc39_walk.sv
// Run store and classifier: one run slot is read and compared with the widest
// run each cycle, building forward and reversed wide masks. Depends on irc39_pkg.
`timescale 1ns / 1ps

module irc39_walk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  irc39_pkg::run_write_t          wr,
    input  logic                           start,
    input  logic [irc39_pkg::TIME_BITS-1:0] widest,
    output irc39_pkg::walk_status_t        status
);
    import irc39_pkg::*;

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(RUN_SLOTS - 1);

    logic [TIME_BITS-1:0] mem [RUN_SLOTS];
    logic [TIME_BITS-1:0] rdata_reg;
    logic [TIME_BITS-1:0] widest_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic                 issue_reg;
    logic                 cmp_valid_reg;
    logic                 cmp_last_reg;
    logic                 done_reg;
    logic [RUN_SLOTS-1:0] fwd_reg;
    logic [RUN_SLOTS-1:0] rev_reg;
    logic [TIME_BITS+1:0] tripled;
    logic                 is_wide;

    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
        rdata_reg <= mem[rd_addr_reg];
    end

    // Narrow when run <= widest/3, i.e. wide when 3*run > widest.
    assign tripled = {1'b0, rdata_reg, 1'b0} + {2'b00, rdata_reg};
    assign is_wide = tripled > {2'b00, widest_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg   <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= issue_reg;
            cmp_last_reg  <= issue_reg && (rd_addr_reg == LAST_ADDR);
            done_reg      <= cmp_valid_reg && cmp_last_reg;
            if (start)
            begin
                issue_reg   <= 1'b1;
                rd_addr_reg <= '0;
            end
            else if (issue_reg)
            begin
                if (rd_addr_reg == LAST_ADDR)
                    issue_reg <= 1'b0;
                else
                    rd_addr_reg <= rd_addr_reg + ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            widest_reg <= widest;
        if (cmp_valid_reg)
        begin
            fwd_reg <= {is_wide, fwd_reg[RUN_SLOTS-1:1]};
            rev_reg <= {rev_reg[RUN_SLOTS-2:0], is_wide};
        end
    end

    assign status.done = done_reg;
    assign status.fwd  = fwd_reg;
    assign status.rev  = rev_reg;

endmodule
